FILE: hw/rtl/q41dp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Q4_1 dot product package
// Shared item type, operand stage records and the single-precision helper
// functions used by the front end and the execution unit.
// ----------------------------------------------------------------------------
package q41dp_pkg;

    // Default depth of the queue between the front end and the execution unit.
    localparam int QUEUE_DEPTH = 2;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] POS_INF   = 32'h7F80_0000;
    localparam logic [7:0]  EXP_MAX   = 8'hFF;

    // One classified item, with all operands already widened to single precision.
    typedef struct packed {
        logic [31:0] scale;
        logic [31:0] offset;
        logic [31:0] q_even;
        logic [31:0] q_odd;
        logic [31:0] act_even;
        logic [31:0] act_odd;
        logic        last;
    } item_t;

    // Multiplier record between the product cycle and the rounding cycle.
    typedef struct packed {
        logic               is_nan;
        logic               is_inf;
        logic               is_zero;
        logic               sign;
        logic signed [10:0] exp;
        logic [47:0]        prod;
    } mul_pre_t;

    // Adder record between the align/add cycle and the normalize/round cycle.
    typedef struct packed {
        logic        is_nan;
        logic        is_inf;
        logic        inf_sign;
        logic        zero_sign;
        logic        sign;
        logic [8:0]  exp;
        logic [27:0] sum;
    } add_pre_t;

    // Count of leading zeros in a 48-bit word.
    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       found;
        n = 6'd48;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 6'(47 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Count of leading zeros in a 27-bit word.
    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd27;
        found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 5'(26 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Exact widening of a half-precision pattern, subnormals included.
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  e;
        logic [9:0]  m;
        logic [3:0]  k;
        logic        found;
        logic [31:0] r;
        logic [10:0] mn;
        e = h[14:10];
        m = h[9:0];
        k = 4'd0;
        found = 1'b0;
        r = {h[15], 31'd0};
        if (e == 5'd0) begin
            if (m != 10'd0) begin
                for (int i = 9; i >= 0; i--) begin
                    if (!found && m[i]) begin
                        k = 4'(10 - i);
                        found = 1'b1;
                    end
                end
                mn = {1'b0, m} << k;
                r = {h[15], 8'(8'd113 - 8'(k)), mn[9:0], 13'd0};
            end
        end else if (e == 5'h1F) begin
            r = {h[15], EXP_MAX, m, 13'd0};
        end else begin
            r = {h[15], 8'(8'(e) + 8'd112), m, 13'd0};
        end
        return r;
    endfunction

    // Small unsigned integer (one nibble) to single precision.
    function automatic logic [31:0] nibble_to_single(input logic [3:0] q);
        logic [1:0]  p;
        logic [26:0] mant;
        logic [31:0] r;
        p = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (q[i]) begin
                p = 2'(i);
            end
        end
        mant = {q, 23'd0} >> p;
        r = (q == 4'd0) ? 32'd0 : {1'b0, 8'(8'd127 + 8'(p)), mant[22:0]};
        return r;
    endfunction

    // Multiply, first cycle: classify and form the 24x24 mantissa product.
    function automatic mul_pre_t fp_mul_pre(input logic [31:0] a, input logic [31:0] b);
        mul_pre_t    r;
        logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [23:0] xa, xb;
        logic [7:0]  ea, eb;
        a_nan  = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
        a_inf  = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
        b_inf  = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        xa = {a[30:23] != 8'd0, a[22:0]};
        xb = {b[30:23] != 8'd0, b[22:0]};
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        r.is_nan  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
        r.is_inf  = a_inf | b_inf;
        r.is_zero = a_zero | b_zero;
        r.sign    = a[31] ^ b[31];
        r.exp     = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd127;
        r.prod    = 48'(xa) * 48'(xb);
        return r;
    endfunction

    // Multiply, second cycle: normalize, denormalize if needed, round to even.
    function automatic logic [31:0] fp_mul_post(input mul_pre_t p);
        logic [5:0]         lz;
        logic [47:0]        n;
        logic [47:0]        mask;
        logic signed [10:0] e;
        logic [5:0]         sh;
        logic               st;
        logic [7:0]         ef;
        logic               inc;
        logic [30:0]        pack;
        logic [31:0]        r;
        lz = lzc48(p.prod);
        n  = p.prod << lz;
        e  = p.exp + 11'sd1 - $signed({5'd0, lz});
        ef = 8'd0;
        if (e < 11'sd1) begin
            sh   = (e < -11'sd46) ? 6'd48 : 6'(11'sd1 - e);
            mask = (48'h1 << sh) - 48'h1;
            st   = |(n & mask);
            n    = n >> sh;
            n[0] = n[0] | st;
        end else begin
            ef = e[7:0];
        end
        inc  = n[23] & ((|n[22:0]) | n[24]);
        pack = {ef, n[46:24]} + 31'(inc);
        if (p.is_nan) begin
            r = CANON_NAN;
        end else if (p.is_inf) begin
            r = {p.sign, POS_INF[30:0]};
        end else if (p.is_zero) begin
            r = {p.sign, 31'd0};
        end else if (e > 11'sd254) begin
            r = {p.sign, POS_INF[30:0]};
        end else begin
            r = {p.sign, pack};
        end
        return r;
    endfunction

    // Add, first cycle: order by magnitude, align the smaller, add or subtract.
    function automatic add_pre_t fp_add_pre(input logic [31:0] a, input logic [31:0] b);
        add_pre_t    r;
        logic        a_nan, b_nan, a_inf, b_inf;
        logic [31:0] big, sml;
        logic [7:0]  eb, es, d;
        logic [4:0]  dc;
        logic [26:0] mb, ms, al, mask;
        logic        st;
        a_nan = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
        a_inf = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
        if (b[30:0] > a[30:0]) begin
            big = b;
            sml = a;
        end else begin
            big = a;
            sml = b;
        end
        eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        mb = {big[30:23] != 8'd0, big[22:0], 3'b000};
        ms = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
        d  = eb - es;
        dc = (d > 8'd27) ? 5'd27 : d[4:0];
        mask = (27'h1 << dc) - 27'h1;
        st = |(ms & mask);
        al = ms >> dc;
        al[0] = al[0] | st;
        r.is_nan    = a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
        r.is_inf    = a_inf | b_inf;
        r.inf_sign  = a_inf ? a[31] : b[31];
        r.zero_sign = a[31] & b[31];
        r.sign      = big[31];
        r.exp       = {1'b0, eb};
        if (a[31] == b[31]) begin
            r.sum = {1'b0, mb} + {1'b0, al};
        end else begin
            r.sum = {1'b0, mb} - {1'b0, al};
        end
        return r;
    endfunction

    // Add, second cycle: normalize, round to even, handle specials.
    function automatic logic [31:0] fp_add_post(input add_pre_t p);
        logic [26:0] s;
        logic [8:0]  e;
        logic [4:0]  lz;
        logic [8:0]  lim;
        logic [4:0]  sh;
        logic [7:0]  ef;
        logic        inc;
        logic [30:0] pack;
        logic [31:0] r;
        lz  = lzc27(p.sum[26:0]);
        lim = p.exp - 9'd1;
        if (p.sum[27]) begin
            s    = p.sum[27:1];
            s[0] = s[0] | p.sum[0];
            e    = p.exp + 9'd1;
        end else begin
            sh = (9'(lz) < lim) ? lz : lim[4:0];
            s  = p.sum[26:0] << sh;
            e  = p.exp - 9'(sh);
        end
        ef   = s[26] ? e[7:0] : 8'd0;
        inc  = s[2] & (s[1] | s[0] | s[3]);
        pack = {ef, s[25:3]} + 31'(inc);
        if (p.is_nan) begin
            r = CANON_NAN;
        end else if (p.is_inf) begin
            r = {p.inf_sign, POS_INF[30:0]};
        end else if (p.sum == 28'd0) begin
            r = {p.zero_sign, 31'd0};
        end else if (e > 9'd254) begin
            r = {p.sign, POS_INF[30:0]};
        end else begin
            r = {p.sign, pack};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/q41dp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Q4_1 dot product front end
// Accepts input items, splits the weight byte and widens the weights, scale
// and offset to single precision before the item is queued for execution.
// ----------------------------------------------------------------------------
module q41dp_front (
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         packed_weights,
    input  wire logic [15:0]        scale_half,
    input  wire logic [15:0]        offset_half,
    input  wire logic [31:0]        act_even,
    input  wire logic [31:0]        act_odd,
    input  wire logic               row_last,
    input  wire logic               queue_full,
    output logic                    push,
    output q41dp_pkg::item_t        push_item
);
    import q41dp_pkg::*;

    // The front end holds off only while the queue has no free entry.
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    // Classify the item into single-precision operands.
    always_comb
    begin
        push_item.scale    = half_to_single(scale_half);
        push_item.offset   = half_to_single(offset_half);
        push_item.q_even   = nibble_to_single(packed_weights[3:0]);
        push_item.q_odd    = nibble_to_single(packed_weights[7:4]);
        push_item.act_even = act_even;
        push_item.act_odd  = act_odd;
        push_item.last     = row_last;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/q41dp_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Q4_1 dot product item queue
// Small first-in first-out queue that decouples the front end from the
// execution unit.
// ----------------------------------------------------------------------------
module q41dp_fifo #(
    parameter int DEPTH = q41dp_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire q41dp_pkg::item_t   push_item,
    output logic                    full,
    input  wire logic               pop,
    output q41dp_pkg::item_t        pop_item,
    output logic                    not_empty
);
    import q41dp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t           mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] ptr);
        return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
    endfunction

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/q41dp_exec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Q4_1 dot product execution unit
// Runs the eight floating-point operations of one item through a shared
// multiplier and a shared adder, keeps the row accumulator and holds the
// finished row sum in an output register.
// ----------------------------------------------------------------------------
module q41dp_exec (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    input  wire q41dp_pkg::item_t   item_in,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [31:0]             row_sum
);
    import q41dp_pkg::*;

    // Operation steps: multiplies at steps 0, 1, 4, 5; adds at the others.
    localparam logic [2:0] LAST_STEP = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_FINISH
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  step_reg, step_next;
    logic [31:0] acc_reg, acc_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] row_sum_reg, row_sum_next;

    item_t       item_reg;
    logic [31:0] t0_reg, t1_reg;
    mul_pre_t    mul_pre_reg;
    add_pre_t    add_pre_reg;

    logic [31:0] op_a, op_b;
    logic [31:0] result;
    logic        is_mul;
    logic        out_free;

    assign is_mul    = !step_reg[1];
    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = (state_reg == ST_IDLE) && item_valid;
    assign out_valid = out_valid_reg;
    assign row_sum   = row_sum_reg;

    // Operand selection for the current step.
    always_comb
    begin
        unique case (step_reg)
            3'd0:    begin op_a = item_reg.scale; op_b = item_reg.q_even;   end
            3'd1:    begin op_a = item_reg.scale; op_b = item_reg.q_odd;    end
            3'd2:    begin op_a = t0_reg;         op_b = item_reg.offset;   end
            3'd3:    begin op_a = t1_reg;         op_b = item_reg.offset;   end
            3'd4:    begin op_a = t0_reg;         op_b = item_reg.act_even; end
            3'd5:    begin op_a = t1_reg;         op_b = item_reg.act_odd;  end
            3'd6:    begin op_a = acc_reg;        op_b = t0_reg;            end
            default: begin op_a = acc_reg;        op_b = t1_reg;            end
        endcase
    end

    // Rounding stage of whichever unit the step uses, fed from its registered record.
    assign result = is_mul ? fp_mul_post(mul_pre_reg) : fp_add_post(add_pre_reg);

    // Sequencer, accumulator and output register.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        row_sum_next   = row_sum_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    step_next  = 3'd0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (step_reg != LAST_STEP)
                begin
                    if (step_reg[2:1] == 2'b11)
                    begin
                        acc_next = result;
                    end
                    step_next  = step_reg + 3'd1;
                    state_next = ST_ISSUE;
                end
                else if (!item_reg.last)
                begin
                    acc_next   = result;
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    // Row done: hand the sum out and restart from +0.0.
                    row_sum_next   = result;
                    out_valid_next = 1'b1;
                    acc_next       = 32'd0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 3'd0;
            acc_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
            row_sum_reg   <= 32'd0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            row_sum_reg   <= row_sum_next;
        end
    end

    // Datapath registers: item operands, temporaries and unit stage records.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= item_in;
        end
        if (state_reg == ST_ISSUE)
        begin
            mul_pre_reg <= fp_mul_pre(op_a, op_b);
            add_pre_reg <= fp_add_pre(op_a, op_b);
        end
        if (state_reg == ST_FINISH && step_reg[2:1] != 2'b11)
        begin
            if (step_reg[0])
            begin
                t1_reg <= result;
            end
            else
            begin
                t0_reg <= result;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/q4_1_dequant_dot_product.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Q4_1 dequantizing dot product
// Accumulates one row of packed 4-bit weights against single-precision
// activations and emits the row sum on the last item of the row.
// ----------------------------------------------------------------------------
// Each item carries one weight byte, its block scale and minimum in half
// precision and two single-precision activations. The front end widens the
// operands and places the item in a small queue, so the input keeps accepting
// while the queue has a free entry. The execution unit performs eight
// separately rounded IEEE single-precision operations per item (two
// dequantizing multiplies and adds, two activation multiplies, two accumulator
// adds) on one shared multiplier and one shared adder, each operation issued
// and then finished in turn; an item is taken from the queue only while the
// execution unit is idle, so it finishes the whole chain before the next. A
// row sum is registered into the output register as the last item finishes
// and waits there until taken; the accumulator then restarts from +0.0. NaN
// results are always the quiet NaN 0x7FC00000, and subnormals are kept.
// ----------------------------------------------------------------------------
module q4_1_dequant_dot_product #(
    parameter int QUEUE_DEPTH = q41dp_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  packed_weights,
    input  wire logic [15:0] scale_half,
    input  wire logic [15:0] offset_half,
    input  wire logic [31:0] act_even,
    input  wire logic [31:0] act_odd,
    input  wire logic        row_last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      row_sum
);
    import q41dp_pkg::*;

    logic  push;
    logic  pop;
    logic  queue_full;
    logic  queue_not_empty;
    item_t push_item;
    item_t pop_item;

    // Item classification.
    q41dp_front u_front (
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .packed_weights (packed_weights),
        .scale_half     (scale_half),
        .offset_half    (offset_half),
        .act_even       (act_even),
        .act_odd        (act_odd),
        .row_last       (row_last),
        .queue_full     (queue_full),
        .push           (push),
        .push_item      (push_item)
    );

    // Queue between front end and execution.
    q41dp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (queue_not_empty)
    );

    // Floating-point execution and accumulation.
    q41dp_exec u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (queue_not_empty),
        .item_in    (pop_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .row_sum    (row_sum)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/q41dp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Q4_1 dot product port checker
// Watches the top-level ports for output handshake and result properties.
// ----------------------------------------------------------------------------
module q41dp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] row_sum
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("row sum withdrawn while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(row_sum))
        else $error("row sum changed while stalled");

    // Any NaN on the output is the canonical quiet NaN.
    a_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_sum[30:23] == 8'hFF && row_sum[22:0] != 23'd0
        |-> row_sum == 32'h7FC0_0000)
        else $error("non-canonical NaN on row sum");

    // The whole operation chain must run first, so no result right after reset.
    a_no_early_sum: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(rst_n, 8))
        else $error("row sum appeared too soon after reset");

endmodule

bind q4_1_dequant_dot_product q41dp_checker u_q41dp_checker (.*);
`default_nettype wire
